@@ rtl/cfs_pkg.sv @@
// Shared types and constants for the Coulomb force sum core.
package cfs_pkg;

  localparam int CoordW = 32;
  localparam int DiffW  = CoordW + 1;
  localparam int RootW  = 33;
  localparam int Rad2W  = 66;
  localparam int UnitW  = 36;
  localparam int AccW   = 48;
  localparam int ScaleW = 32;
  localparam int ScaleFrac = 16;
  localparam int HalfW  = 24;
  localparam int SqrtSteps = 33;

  localparam logic [AccW:0] TERM_CAP = {1'b1, {AccW{1'b0}}};
  localparam logic signed [AccW-1:0] ACC_MAX = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] ACC_MIN = {1'b1, {(AccW-1){1'b0}}};

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [1:0] CFG_ION_COUNT   = 2'd0;
  localparam logic [1:0] CFG_FORCE_SCALE = 2'd1;
  localparam logic [1:0] AXIS_NONE       = 2'd3;

  typedef struct packed {
    logic [UnitW-1:0] a;
    logic [UnitW-1:0] b;
  } unit_req_t;

  typedef struct packed {
    logic             ge;
    logic [UnitW-1:0] diff;
  } unit_rsp_t;

endpackage

@@ rtl/cfs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cfs_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/cfs_cmpsub.sv @@
// Shared compare-and-subtract unit for the square root and division steps.
module cfs_cmpsub (
  input  cfs_pkg::unit_req_t req,
  output cfs_pkg::unit_rsp_t rsp
);
  always_comb begin
    rsp.ge   = (req.a >= req.b);
    rsp.diff = req.a - req.b;
  end
endmodule

@@ rtl/coulomb_force_sum_core.sv @@
// Coulomb force direct-sum core: position store, sequencer and shared datapath.
// Each used ion other than the queried one is processed by the bit-serial square root and three
// restoring divisions through the one compare-subtract unit; a coincident ion skips both, and an
// invalid query goes straight to the result. in_tready is high only while idle.
// rst_n (sync, active low) clears sequencer, output valid and config; positions are kept.
module coulomb_force_sum_core #(
  parameter int MAX_IONS  = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,   // ion_index[5:0], axis[7:6], pos_x, pos_y, pos_z
  input  logic         in_tuser,   // kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [55:0]  out_tdata,  // force_res[47:0], overflow[48], coincident[49], zero pad
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  localparam int AW  = $clog2(MAX_IONS);
  localparam int DW  = cfs_pkg::DiffW + 3 * FRAC_BITS;  // dividend width
  localparam int SH3 = 3 * FRAC_BITS;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SELF  = 4'd1;
  localparam logic [3:0] S_NEXT  = 4'd2;
  localparam logic [3:0] S_LOAD  = 4'd3;
  localparam logic [3:0] S_SQ    = 4'd4;
  localparam logic [3:0] S_SQRT  = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_ACC   = 4'd7;
  localparam logic [3:0] S_SCL0  = 4'd8;
  localparam logic [3:0] S_SCL1  = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  // config
  logic [6:0]  ion_count_r;
  logic [31:0] force_scale_r;

  // input fields
  logic [5:0]  in_idx;
  logic [1:0]  in_axis;
  assign in_idx  = in_tdata[5:0];
  assign in_axis = in_tdata[7:6];

  logic [3:0]  state_r, state_nxt;
  logic [5:0]  idx_r, idx_nxt;
  logic [1:0]  axis_r, axis_nxt;
  logic [6:0]  n_r, n_nxt;
  logic [6:0]  step_r, step_nxt;
  logic [1:0]  k_r, k_nxt;
  logic [1:0]  pass_r, pass_nxt;
  logic [cfs_pkg::CoordW-1:0] self_r [3];
  logic [cfs_pkg::CoordW-1:0] self_nxt [3];
  logic signed [cfs_pkg::DiffW-1:0] dif_r [3];
  logic signed [cfs_pkg::DiffW-1:0] dif_nxt [3];
  logic [cfs_pkg::Rad2W-1:0] rad_r, rad_nxt;
  logic [cfs_pkg::RootW-1:0] root_r, root_nxt;
  logic [cfs_pkg::RootW:0]   rem_r, rem_nxt;
  logic [DW-1:0]             num_r, num_nxt;
  logic signed [cfs_pkg::AccW-1:0] acc_r, acc_nxt;
  logic        ovf_r, ovf_nxt, coin_r, coin_nxt;
  logic [55:0] plo_r, plo_nxt;
  logic signed [cfs_pkg::AccW-1:0] fres_r, fres_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [55:0] out_data_r, out_data_nxt;

  logic [6:0]  count_eff;
  logic        in_xfer, idx_ok, mem_we;
  logic [95:0] ram_rdata;
  logic [AW-1:0] raddr;

  assign count_eff = (32'(ion_count_r) > MAX_IONS) ? 7'(MAX_IONS) : ion_count_r;
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign idx_ok    = (32'(in_idx) < MAX_IONS);
  assign mem_we    = in_xfer && (in_tuser == cfs_pkg::KIND_WRITE) && idx_ok;
  assign raddr     = (state_r == S_IDLE) ? AW'(in_idx) : AW'(n_r);

  cfs_ram #(.W(96), .D(MAX_IONS)) u_pos (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(in_idx)),
    .wdata (in_tdata[103:8]),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // shared compare-subtract unit
  cfs_pkg::unit_req_t ureq;
  cfs_pkg::unit_rsp_t ursp;
  cfs_cmpsub u_unit (.req(ureq), .rsp(ursp));

  always_comb begin
    if (state_r == S_SQRT) begin
      ureq.a = {rem_r[33:0], rad_r[cfs_pkg::Rad2W-1 -: 2]};
      ureq.b = {1'b0, root_r, 2'b01};
    end else begin
      ureq.a = {2'b00, rem_r[32:0], num_r[DW-1]};
      ureq.b = {3'b000, root_r};
    end
  end

  // shared multiplier: squares, then the two halves of the scaling product
  logic [cfs_pkg::DiffW-1:0] mul_a, mul_b;
  logic [2*cfs_pkg::DiffW-1:0] mul_p;
  logic [cfs_pkg::DiffW-1:0] sqmag;
  logic [cfs_pkg::AccW-1:0]  acc_mag;

  assign sqmag   = dif_r[k_r][cfs_pkg::DiffW-1] ? cfs_pkg::DiffW'(-dif_r[k_r])
                                                : cfs_pkg::DiffW'(dif_r[k_r]);
  assign acc_mag = acc_r[cfs_pkg::AccW-1] ? cfs_pkg::AccW'(-acc_r) : cfs_pkg::AccW'(acc_r);

  always_comb begin
    case (state_r)
      S_SCL0: begin
        mul_a = cfs_pkg::DiffW'(acc_mag[cfs_pkg::HalfW-1:0]);
        mul_b = cfs_pkg::DiffW'(force_scale_r);
      end
      S_SCL1: begin
        mul_a = cfs_pkg::DiffW'(acc_mag[cfs_pkg::AccW-1:cfs_pkg::HalfW]);
        mul_b = cfs_pkg::DiffW'(force_scale_r);
      end
      default: begin
        mul_a = sqmag;
        mul_b = sqmag;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // term and accumulator
  logic signed [cfs_pkg::DiffW-1:0] dax;
  logic [cfs_pkg::DiffW-1:0] dmag;
  logic [cfs_pkg::AccW:0]    term_mag;
  logic signed [cfs_pkg::AccW+1:0] sum;
  logic [79:0] prod;
  logic [63:0] q;

  assign dax  = dif_r[axis_r];
  assign dmag = dax[cfs_pkg::DiffW-1] ? cfs_pkg::DiffW'(-dax) : cfs_pkg::DiffW'(dax);
  assign term_mag = (num_r > DW'(cfs_pkg::TERM_CAP)) ? cfs_pkg::TERM_CAP
                                                     : (cfs_pkg::AccW+1)'(num_r);
  assign sum = dax[cfs_pkg::DiffW-1]
             ? ((cfs_pkg::AccW+2)'(acc_r) - $signed({1'b0, term_mag}))
             : ((cfs_pkg::AccW+2)'(acc_r) + $signed({1'b0, term_mag}));
  assign prod = 80'(plo_r) + (80'(mul_p[55:0]) << cfs_pkg::HalfW);
  assign q    = prod[79:cfs_pkg::ScaleFrac];

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    axis_nxt = axis_r;
    n_nxt = n_r;
    step_nxt = step_r;
    k_nxt = k_r;
    pass_nxt = pass_r;
    self_nxt = self_r;
    dif_nxt = dif_r;
    rad_nxt = rad_r;
    root_nxt = root_r;
    rem_nxt = rem_r;
    num_nxt = num_r;
    acc_nxt = acc_r;
    ovf_nxt = ovf_r;
    coin_nxt = coin_r;
    plo_nxt = plo_r;
    fres_nxt = fres_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer && in_tuser == cfs_pkg::KIND_QUERY) begin
          idx_nxt = in_idx;
          axis_nxt = in_axis;
          acc_nxt = '0;
          ovf_nxt = 1'b0;
          coin_nxt = 1'b0;
          fres_nxt = '0;
          if (!idx_ok || in_axis == cfs_pkg::AXIS_NONE) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_SELF;
          end
        end
      end
      S_SELF: begin
        self_nxt[0] = ram_rdata[31:0];
        self_nxt[1] = ram_rdata[63:32];
        self_nxt[2] = ram_rdata[95:64];
        n_nxt = '0;
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        if (n_r >= count_eff) begin
          state_nxt = S_SCL0;
        end else if (n_r == {1'b0, idx_r}) begin
          n_nxt = n_r + 7'd1;
        end else begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          dif_nxt[i] = $signed({self_r[i][31], self_r[i]})
                     - $signed({ram_rdata[32*i+31], ram_rdata[32*i +: 32]});
        end
        rad_nxt = '0;
        k_nxt = '0;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        rad_nxt = rad_r + mul_p;
        k_nxt = k_r + 2'd1;
        if (k_r == 2'd2) begin
          if ((rad_r + mul_p) == '0) begin
            coin_nxt = 1'b1;
            n_nxt = n_r + 7'd1;
            state_nxt = S_NEXT;
          end else begin
            root_nxt = '0;
            rem_nxt = '0;
            step_nxt = '0;
            state_nxt = S_SQRT;
          end
        end
      end
      S_SQRT: begin
        rem_nxt = ursp.ge ? ursp.diff[33:0] : ureq.a[33:0];
        root_nxt = {root_r[cfs_pkg::RootW-2:0], ursp.ge};
        rad_nxt = rad_r << 2;
        step_nxt = step_r + 7'd1;
        if (step_r == 7'(cfs_pkg::SqrtSteps - 1)) begin
          num_nxt = DW'(dmag) << SH3;
          step_nxt = '0;
          pass_nxt = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (step_r == '0) begin
          rem_nxt = '0;
          num_nxt = num_r;
          step_nxt = 7'd1;
        end else begin
          rem_nxt = ursp.ge ? {1'b0, ursp.diff[32:0]} : {1'b0, ureq.a[32:0]};
          num_nxt = {num_r[DW-2:0], ursp.ge};
          step_nxt = step_r + 7'd1;
          if (step_r == 7'(DW)) begin
            step_nxt = '0;
            pass_nxt = pass_r + 2'd1;
            if (pass_r == 2'd2) begin
              state_nxt = S_ACC;
            end
          end
        end
      end
      S_ACC: begin
        if (sum > (cfs_pkg::AccW+2)'(cfs_pkg::ACC_MAX)) begin
          acc_nxt = cfs_pkg::ACC_MAX;
          ovf_nxt = 1'b1;
        end else if (sum < (cfs_pkg::AccW+2)'(cfs_pkg::ACC_MIN)) begin
          acc_nxt = cfs_pkg::ACC_MIN;
          ovf_nxt = 1'b1;
        end else begin
          acc_nxt = cfs_pkg::AccW'(sum);
        end
        n_nxt = n_r + 7'd1;
        state_nxt = S_NEXT;
      end
      S_SCL0: begin
        plo_nxt = mul_p[55:0];
        state_nxt = S_SCL1;
      end
      S_SCL1: begin
        if (!acc_r[cfs_pkg::AccW-1]) begin
          if (q > 64'(cfs_pkg::ACC_MAX)) begin
            fres_nxt = cfs_pkg::ACC_MAX;
            ovf_nxt = 1'b1;
          end else begin
            fres_nxt = cfs_pkg::AccW'(q);
          end
        end else begin
          if (q > 64'(cfs_pkg::TERM_CAP >> 1)) begin
            fres_nxt = cfs_pkg::ACC_MIN;
            ovf_nxt = 1'b1;
          end else begin
            fres_nxt = cfs_pkg::AccW'(-q);
          end
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt = {6'b0, coin_r, ovf_r, fres_r};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      ion_count_r <= '0;
      force_scale_r <= 32'd65536;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == cfs_pkg::CFG_ION_COUNT) begin
        ion_count_r <= cfg_data[6:0];
      end
      if (cfg_we && cfg_index == cfs_pkg::CFG_FORCE_SCALE) begin
        force_scale_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    axis_r <= axis_nxt;
    n_r <= n_nxt;
    step_r <= step_nxt;
    k_r <= k_nxt;
    pass_r <= pass_nxt;
    self_r <= self_nxt;
    dif_r <= dif_nxt;
    rad_r <= rad_nxt;
    root_r <= root_nxt;
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    acc_r <= acc_nxt;
    ovf_r <= ovf_nxt;
    coin_r <= coin_nxt;
    plo_r <= plo_nxt;
    fres_r <= fres_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef ASSERT_OFF
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (root_r != '0))
    else $error("divisor is zero");
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && step_r != '0) |-> ({1'b0, root_r} > rem_r))
    else $error("division remainder not below divisor");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NEXT) |-> (n_r <= count_eff))
    else $error("ion counter overran");
  a_sqrt_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQRT) |-> (step_r < 7'(cfs_pkg::SqrtSteps)))
    else $error("square root step count overran");
`endif
endmodule
